// File: sv/ibrs_pkg.sv
package ibrs_pkg;

	// Number of data bytes read in one burst (1 to 16)
	localparam int READ_LENGTH = 10;

	localparam int STEP_W = $clog2(READ_LENGTH + 5);
	localparam int SLOT_W = 4;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE       = step_t'(0);
	localparam step_t STEP_ADDR_W     = step_t'(1);
	localparam step_t STEP_REG_PTR    = step_t'(2);
	localparam step_t STEP_RESTARTED  = step_t'(3);
	localparam step_t STEP_ADDR_R     = step_t'(4);
	localparam step_t FIRST_DATA_STEP = step_t'(5);
	localparam step_t LAST_DATA_STEP  = step_t'(4 + READ_LENGTH);

	// Controller status codes, low three bits masked off
	localparam logic [7:0] ST_MASK       = 8'hF8;
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
	localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_TRANSMIT = 3'd1,
		ACT_RESTART  = 3'd2,
		ACT_RX_ACK   = 3'd3,
		ACT_RX_NACK  = 3'd4
	} action_t;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_REGISTER = 1'd1;

	typedef struct packed {
		logic [7:0] device_address_byte;
		logic [7:0] start_register;
	} cfg_t;

	typedef struct packed {
		logic [7:0] bus_status;
		logic [7:0] received_byte;
	} req_t;

	typedef struct packed {
		action_t           bus_action;
		logic [7:0]        transmit_byte;
		logic              capture_valid;
		logic [SLOT_W-1:0] capture_slot;
		logic [7:0]        capture_value;
	} rsp_t;

endpackage

// File: sv/i2c_register_burst_read_sequencer.sv
// I2C register burst-read sequencer. Each req word is one status event from an I2C
// master controller (status byte, upper five bits decoded, plus the byte just received);
// each rsp word is the bus action to take next, the byte to transmit, and any captured
// data byte with its slot number. The block walks START, write address, register pointer,
// repeated START, read address, then READ_LENGTH data bytes (last one NACKed) and starts
// over; an unknown status restarts it. One word is accepted every cycle while results are
// taken. A word waits in the input register until it advances, and the step decode then
// writes the result register, which drives rsp_valid and rsp; a word passes through the
// input register and then the result register before it can be taken at the earliest. A
// stalled result holds the input register, so a further word then stalls req. The only
// loop is the sequence step register, updated once per word as it leaves the input
// register. Write device_address_byte (index 0) and start_register (index 1) through
// cfg_we/cfg_index/cfg_data while no word is in flight.
module i2c_register_burst_read_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  ibrs_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output ibrs_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [ibrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_data
);

	ibrs_pkg::cfg_t cfg_q;
	ibrs_pkg::req_t req_s1;
	logic           valid_s1;
	ibrs_pkg::rsp_t rsp_s2;
	logic           valid_s2;
	ibrs_pkg::rsp_t result;
	logic           advance;

	// Move the held word into the result register when that register is free or drained.
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	// Stall the requester only while the input register is full and cannot advance.
	assign req_stall = valid_s1 && !advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ibrs_pkg::REG_DEVICE_ADDRESS: cfg_q.device_address_byte <= cfg_data;
				ibrs_pkg::REG_START_REGISTER: cfg_q.start_register      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: load a new word whenever the stage is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	ibrs_step_unit u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result register: fill on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

// File: sv/ibrs_step_unit.sv
module ibrs_step_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  ibrs_pkg::req_t req,
	input  ibrs_pkg::cfg_t cfg,
	output ibrs_pkg::rsp_t result
);

	ibrs_pkg::step_t step_q;
	ibrs_pkg::step_t step_next;
	ibrs_pkg::step_t slot_full;
	logic [7:0]      status_m;

	assign status_m  = req.bus_status & ibrs_pkg::ST_MASK;
	assign slot_full = step_q - ibrs_pkg::FIRST_DATA_STEP;

	always_comb begin
		step_next = step_q;
		result    = '0;
		result.bus_action = ibrs_pkg::ACT_NONE;
		case (status_m)
			ibrs_pkg::ST_START, ibrs_pkg::ST_RESTART: begin
				if (status_m == ibrs_pkg::ST_RESTART && step_q == ibrs_pkg::STEP_RESTARTED) begin
					result.bus_action    = ibrs_pkg::ACT_TRANSMIT;
					result.transmit_byte = cfg.device_address_byte | 8'h01;
					step_next            = ibrs_pkg::STEP_ADDR_R;
				end else if (step_q == ibrs_pkg::STEP_IDLE) begin
					result.bus_action    = ibrs_pkg::ACT_TRANSMIT;
					result.transmit_byte = cfg.device_address_byte;
					step_next            = ibrs_pkg::STEP_ADDR_W;
				end
			end
			ibrs_pkg::ST_SLA_W_ACK: begin
				if (step_q == ibrs_pkg::STEP_ADDR_W) begin
					result.bus_action    = ibrs_pkg::ACT_TRANSMIT;
					result.transmit_byte = cfg.start_register;
					step_next            = ibrs_pkg::STEP_REG_PTR;
				end
			end
			ibrs_pkg::ST_DATA_W_ACK: begin
				if (step_q == ibrs_pkg::STEP_REG_PTR) begin
					result.bus_action = ibrs_pkg::ACT_RESTART;
					step_next         = ibrs_pkg::STEP_RESTARTED;
				end
			end
			ibrs_pkg::ST_SLA_R_ACK: begin
				if (step_q == ibrs_pkg::STEP_ADDR_R) begin
					result.bus_action = (ibrs_pkg::READ_LENGTH > 1) ?
						ibrs_pkg::ACT_RX_ACK : ibrs_pkg::ACT_RX_NACK;
					step_next = ibrs_pkg::FIRST_DATA_STEP;
				end
			end
			ibrs_pkg::ST_DATA_R_ACK: begin
				if (step_q >= ibrs_pkg::FIRST_DATA_STEP && step_q < ibrs_pkg::LAST_DATA_STEP) begin
					result.capture_valid = 1'b1;
					result.capture_slot  = ibrs_pkg::SLOT_W'(slot_full);
					result.capture_value = req.received_byte;
					// next byte is the last one: ask for it with a NACK
					result.bus_action = (step_q < ibrs_pkg::LAST_DATA_STEP - ibrs_pkg::step_t'(1)) ?
						ibrs_pkg::ACT_RX_ACK : ibrs_pkg::ACT_RX_NACK;
					step_next = step_q + ibrs_pkg::step_t'(1);
				end
			end
			ibrs_pkg::ST_DATA_R_NAK: begin
				if (step_q == ibrs_pkg::LAST_DATA_STEP) begin
					result.capture_valid = 1'b1;
					result.capture_slot  = ibrs_pkg::SLOT_W'(slot_full);
					result.capture_value = req.received_byte;
					result.bus_action    = ibrs_pkg::ACT_RESTART;
					step_next            = ibrs_pkg::STEP_IDLE;
				end
			end
			default: begin
				result.bus_action = ibrs_pkg::ACT_RESTART;
				step_next         = ibrs_pkg::STEP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ibrs_pkg::STEP_IDLE;
		end else if (advance) begin
			step_q <= step_next;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ibrs_pkg::LAST_DATA_STEP)
		else $error("sequence step beyond last data step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(step_q))
		else $error("sequence step moved without an event");

	a_restart_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.bus_action == ibrs_pkg::ACT_RESTART
		|=> step_q == ibrs_pkg::STEP_IDLE || step_q == ibrs_pkg::STEP_RESTARTED)
		else $error("restart left the step in a data or address phase");

	a_first_data: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status_m == ibrs_pkg::ST_SLA_R_ACK && step_q == ibrs_pkg::STEP_ADDR_R
		|=> step_q == ibrs_pkg::FIRST_DATA_STEP)
		else $error("read address ack did not enter first data step");

endmodule
